// File: hw/rtl/kt_pkg.sv
// ----------------------------------------------------------------------------
// kt_pkg: shared types, constants and microcode for the 3-axis tracker
// fixed-point constants, operand codes, micro-op format and the program rom
// ----------------------------------------------------------------------------
`default_nettype none

package kt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int DT_W      = 17;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int PC_W      = 6;
  localparam int NTMP      = 28;
  localparam int TMP_IW    = $clog2(NTMP);

  localparam logic signed [DATA_W-1:0] ONE_FX     = DATA_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [DATA_W-1:0] HALF_FX    = DATA_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [DATA_W-1:0] QUARTER_FX = DATA_W'(64'sd1 <<< (FRAC_BITS - 2));
  localparam logic signed [DATA_W-1:0] TEN_FX     = DATA_W'(64'sd10 <<< FRAC_BITS);
  localparam logic signed [DATA_W-1:0] MAX_FX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_FX     = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [DT_W-1:0]  DT_RESET    = DT_W'(6554);
  localparam logic [CFG_W-1:0] NOISE_RESET = CFG_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP    = 3'd0,
    REG_MEAS_NOISE_X = 3'd1,
    REG_MEAS_NOISE_Y = 3'd2,
    REG_MEAS_NOISE_Z = 3'd3,
    REG_ACCEL_NOISE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    UOP_MUL,
    UOP_ADD,
    UOP_SUB,
    UOP_DIV
  } uop_op_t;

  // operand codes; everything from OP_DT2 on lives in the temporary file
  typedef enum logic [5:0] {
    OP_ZERO, OP_ONE, OP_HALF, OP_QUARTER, OP_DT, OP_SA, OP_SIG, OP_MEAS,
    OP_ACC, OP_EP, OP_EV, OP_C0, OP_C1, OP_C2,
    OP_DT2, OP_DT3, OP_DT4, OP_S2, OP_GP, OP_QPP, OP_QPV, OP_QVV,
    OP_R, OP_A1, OP_A2, OP_P, OP_V, OP_T, OP_P00, OP_P01, OP_P11,
    OP_K0, OP_K1, OP_Y, OP_GA, OP_GB, OP_M00, OP_M01, OP_M10, OP_M11,
    OP_KR0, OP_KR1
  } opnd_t;

  typedef struct packed {
    uop_op_t op;
    opnd_t   dst;
    opnd_t   sa;
    opnd_t   sb;
    opnd_t   sc;
    opnd_t   sd;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MULWB,
    ST_DIVWAIT,
    ST_ROTATE,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    uop_t       uop;
    logic [1:0] axis;
    logic       wr_en;
    logic       div_go;
    logic       rotate;
    logic       finish;
    logic       wait_div;
  } ctrl_t;

  localparam logic [PC_W-1:0] AXIS_START = PC_W'(10);
  localparam logic [PC_W-1:0] PROG_LAST  = PC_W'(48);

  function automatic uop_t mk(uop_op_t op, opnd_t d, opnd_t a, opnd_t b,
                              opnd_t c, opnd_t e);
    uop_t u;
    u.op = op; u.dst = d; u.sa = a; u.sb = b; u.sc = c; u.sd = e;
    return u;
  endfunction

  // common terms first, then the per-axis program
  function automatic uop_t prog(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(UOP_MUL, OP_DT2, OP_DT,  OP_DT,      OP_ZERO, OP_ZERO);
      6'd1:  u = mk(UOP_MUL, OP_DT3, OP_DT2, OP_DT,      OP_ZERO, OP_ZERO);
      6'd2:  u = mk(UOP_MUL, OP_DT4, OP_DT3, OP_DT,      OP_ZERO, OP_ZERO);
      6'd3:  u = mk(UOP_MUL, OP_S2,  OP_SA,  OP_SA,      OP_ZERO, OP_ZERO);
      6'd4:  u = mk(UOP_MUL, OP_A1,  OP_DT4, OP_QUARTER, OP_ZERO, OP_ZERO);
      6'd5:  u = mk(UOP_MUL, OP_QPP, OP_A1,  OP_S2,      OP_ZERO, OP_ZERO);
      6'd6:  u = mk(UOP_MUL, OP_A1,  OP_DT3, OP_HALF,    OP_ZERO, OP_ZERO);
      6'd7:  u = mk(UOP_MUL, OP_QPV, OP_A1,  OP_S2,      OP_ZERO, OP_ZERO);
      6'd8:  u = mk(UOP_MUL, OP_QVV, OP_DT2, OP_S2,      OP_ZERO, OP_ZERO);
      6'd9:  u = mk(UOP_MUL, OP_GP,  OP_DT2, OP_HALF,    OP_ZERO, OP_ZERO);
      6'd10: u = mk(UOP_MUL, OP_R,   OP_SIG, OP_SIG,     OP_ZERO, OP_ZERO);
      6'd11: u = mk(UOP_MUL, OP_A1,  OP_DT,  OP_EV,      OP_ZERO, OP_ZERO);
      6'd12: u = mk(UOP_MUL, OP_A2,  OP_GP,  OP_ACC,     OP_ZERO, OP_ZERO);
      6'd13: u = mk(UOP_ADD, OP_P,   OP_EP,  OP_A1,      OP_A2,   OP_ZERO);
      6'd14: u = mk(UOP_MUL, OP_A1,  OP_DT,  OP_ACC,     OP_ZERO, OP_ZERO);
      6'd15: u = mk(UOP_ADD, OP_V,   OP_EV,  OP_A1,      OP_ZERO, OP_ZERO);
      6'd16: u = mk(UOP_MUL, OP_A1,  OP_DT,  OP_C2,      OP_ZERO, OP_ZERO);
      6'd17: u = mk(UOP_ADD, OP_T,   OP_C1,  OP_A1,      OP_ZERO, OP_ZERO);
      6'd18: u = mk(UOP_MUL, OP_A1,  OP_DT,  OP_C1,      OP_ZERO, OP_ZERO);
      6'd19: u = mk(UOP_MUL, OP_A2,  OP_DT,  OP_T,       OP_ZERO, OP_ZERO);
      6'd20: u = mk(UOP_ADD, OP_P00, OP_C0,  OP_A1,      OP_A2,   OP_QPP);
      6'd21: u = mk(UOP_ADD, OP_P01, OP_T,   OP_QPV,     OP_ZERO, OP_ZERO);
      6'd22: u = mk(UOP_ADD, OP_P11, OP_C2,  OP_QVV,     OP_ZERO, OP_ZERO);
      6'd23: u = mk(UOP_DIV, OP_K0,  OP_P00, OP_P00,     OP_R,    OP_ZERO);
      6'd24: u = mk(UOP_DIV, OP_K1,  OP_P01, OP_P00,     OP_R,    OP_ZERO);
      6'd25: u = mk(UOP_SUB, OP_Y,   OP_MEAS, OP_ZERO,   OP_ZERO, OP_P);
      6'd26: u = mk(UOP_MUL, OP_A1,  OP_K0,  OP_Y,       OP_ZERO, OP_ZERO);
      6'd27: u = mk(UOP_ADD, OP_EP,  OP_P,   OP_A1,      OP_ZERO, OP_ZERO);
      6'd28: u = mk(UOP_MUL, OP_A1,  OP_K1,  OP_Y,       OP_ZERO, OP_ZERO);
      6'd29: u = mk(UOP_ADD, OP_EV,  OP_V,   OP_A1,      OP_ZERO, OP_ZERO);
      6'd30: u = mk(UOP_SUB, OP_GA,  OP_ONE, OP_ZERO,    OP_ZERO, OP_K0);
      6'd31: u = mk(UOP_SUB, OP_GB,  OP_ZERO, OP_ZERO,   OP_ZERO, OP_K1);
      6'd32: u = mk(UOP_MUL, OP_M00, OP_GA,  OP_P00,     OP_ZERO, OP_ZERO);
      6'd33: u = mk(UOP_MUL, OP_M01, OP_GA,  OP_P01,     OP_ZERO, OP_ZERO);
      6'd34: u = mk(UOP_MUL, OP_A1,  OP_GB,  OP_P00,     OP_ZERO, OP_ZERO);
      6'd35: u = mk(UOP_ADD, OP_M10, OP_A1,  OP_P01,     OP_ZERO, OP_ZERO);
      6'd36: u = mk(UOP_MUL, OP_A1,  OP_GB,  OP_P01,     OP_ZERO, OP_ZERO);
      6'd37: u = mk(UOP_ADD, OP_M11, OP_A1,  OP_P11,     OP_ZERO, OP_ZERO);
      6'd38: u = mk(UOP_MUL, OP_KR0, OP_K0,  OP_R,       OP_ZERO, OP_ZERO);
      6'd39: u = mk(UOP_MUL, OP_KR1, OP_K1,  OP_R,       OP_ZERO, OP_ZERO);
      6'd40: u = mk(UOP_MUL, OP_A1,  OP_M00, OP_GA,      OP_ZERO, OP_ZERO);
      6'd41: u = mk(UOP_MUL, OP_A2,  OP_KR0, OP_K0,      OP_ZERO, OP_ZERO);
      6'd42: u = mk(UOP_ADD, OP_C0,  OP_A1,  OP_A2,      OP_ZERO, OP_ZERO);
      6'd43: u = mk(UOP_MUL, OP_A1,  OP_M00, OP_GB,      OP_ZERO, OP_ZERO);
      6'd44: u = mk(UOP_MUL, OP_A2,  OP_KR0, OP_K1,      OP_ZERO, OP_ZERO);
      6'd45: u = mk(UOP_ADD, OP_C1,  OP_A1,  OP_M01,     OP_A2,   OP_ZERO);
      6'd46: u = mk(UOP_MUL, OP_A1,  OP_M10, OP_GB,      OP_ZERO, OP_ZERO);
      6'd47: u = mk(UOP_MUL, OP_A2,  OP_KR1, OP_K1,      OP_ZERO, OP_ZERO);
      6'd48: u = mk(UOP_ADD, OP_C2,  OP_A1,  OP_M11,     OP_A2,   OP_ZERO);
      default: u = mk(UOP_ADD, OP_A1, OP_ZERO, OP_ZERO,  OP_ZERO, OP_ZERO);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/kalman_tracker_3axis.sv
// the time from input transfer to result is set by the shared multiplier and the radix-2
//   gain divider (48 steps, twice per axis)
// a new item is taken only once the previous one is finished, while its result may still
//   wait in the output register
// reset: estimates and stored accelerations go to zero, covariance to ten on the diagonal,
//   registers to their reset values
// ----------------------------------------------------------------------------
// kalman_tracker_3axis: constant-velocity Kalman tracker, three axes
// one multiplier, one adder and one divider shared under a microcode sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_tracker_3axis
  import kt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration write port
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  // input item
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DATA_W-1:0] meas_x,
  input  wire logic signed [DATA_W-1:0] meas_y,
  input  wire logic signed [DATA_W-1:0] meas_z,
  input  wire logic signed [DATA_W-1:0] accel_x,
  input  wire logic signed [DATA_W-1:0] accel_y,
  input  wire logic signed [DATA_W-1:0] accel_z,
  // result item
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      pos_x,
  output logic signed [DATA_W-1:0]      vel_x,
  output logic signed [DATA_W-1:0]      pos_y,
  output logic signed [DATA_W-1:0]      vel_y,
  output logic signed [DATA_W-1:0]      pos_z,
  output logic signed [DATA_W-1:0]      vel_z
);

  // configuration registers
  logic [DT_W-1:0]  time_step;
  logic [CFG_W-1:0] meas_noise_x, meas_noise_y, meas_noise_z, accel_noise;

  // latched input item and the accelerations of the previous item
  logic signed [DATA_W-1:0] mx, my, mz, ax_in, ay_in, az_in;
  logic signed [DATA_W-1:0] pacc_x, pacc_y, pacc_z;

  // axis state; slot 0 always holds the axis in work, rotated after each axis
  logic signed [DATA_W-1:0] est_p [3];
  logic signed [DATA_W-1:0] est_v [3];
  logic signed [DATA_W-1:0] cov0  [3];
  logic signed [DATA_W-1:0] cov1  [3];
  logic signed [DATA_W-1:0] cov2  [3];

  // temporary file for the microcode
  logic signed [DATA_W-1:0] tmp [NTMP];

  ctrl_t ctrl;
  logic  seq_idle;
  logic  in_xfer;
  logic  div_done;

  logic signed [DATA_W-1:0] opv [4];
  opnd_t                    osel [4];
  logic signed [DATA_W-1:0] sig_cur, meas_cur, acc_cur;
  logic signed [DATA_W-1:0] mul_res, div_res, add_res, wdata;
  logic signed [DATA_W+2:0] add_sum;
  logic [TMP_IW-1:0]        tidx;

  assign in_ready = seq_idle;
  assign in_xfer  = in_valid && in_ready;

  kt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_xfer),
    .div_done (div_done),
    .out_busy (out_valid && !out_ready),
    .idle     (seq_idle),
    .ctrl     (ctrl)
  );

  // per-axis selections that do not rotate
  always_comb begin
    unique case (ctrl.axis)
      2'd0: begin
        sig_cur = DATA_W'(meas_noise_x); meas_cur = mx; acc_cur = pacc_x;
      end
      2'd1: begin
        sig_cur = DATA_W'(meas_noise_y); meas_cur = my; acc_cur = pacc_y;
      end
      default: begin
        sig_cur = DATA_W'(meas_noise_z); meas_cur = mz; acc_cur = pacc_z;
      end
    endcase
  end

  // operand read muxes
  always_comb begin
    osel[0] = ctrl.uop.sa;
    osel[1] = ctrl.uop.sb;
    osel[2] = ctrl.uop.sc;
    osel[3] = ctrl.uop.sd;
    for (int i = 0; i < 4; i++) begin
      case (osel[i])
        OP_ZERO:    opv[i] = '0;
        OP_ONE:     opv[i] = ONE_FX;
        OP_HALF:    opv[i] = HALF_FX;
        OP_QUARTER: opv[i] = QUARTER_FX;
        OP_DT:      opv[i] = DATA_W'(time_step);
        OP_SA:      opv[i] = DATA_W'(accel_noise);
        OP_SIG:     opv[i] = sig_cur;
        OP_MEAS:    opv[i] = meas_cur;
        OP_ACC:     opv[i] = acc_cur;
        OP_EP:      opv[i] = est_p[0];
        OP_EV:      opv[i] = est_v[0];
        OP_C0:      opv[i] = cov0[0];
        OP_C1:      opv[i] = cov1[0];
        OP_C2:      opv[i] = cov2[0];
        default:    opv[i] = tmp[TMP_IW'(osel[i] - OP_DT2)];
      endcase
    end
  end

  kt_mul u_mul (
    .clk (clk),
    .a   (opv[0]),
    .b   (opv[1]),
    .res (mul_res)
  );

  kt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (ctrl.div_go),
    .num  (opv[0]),
    .p00  (opv[1]),
    .r    (opv[2]),
    .done (div_done),
    .res  (div_res)
  );

  // four-term saturating adder, last term negated for subtracts
  always_comb begin
    add_sum = (DATA_W+3)'(opv[0]) + (DATA_W+3)'(opv[1]) + (DATA_W+3)'(opv[2]);
    if (ctrl.uop.op == UOP_SUB) begin
      add_sum = add_sum - (DATA_W+3)'(opv[3]);
    end else begin
      add_sum = add_sum + (DATA_W+3)'(opv[3]);
    end
    if (add_sum > (DATA_W+3)'(MAX_FX)) begin
      add_res = MAX_FX;
    end else if (add_sum < (DATA_W+3)'(MIN_FX)) begin
      add_res = MIN_FX;
    end else begin
      add_res = add_sum[DATA_W-1:0];
    end
  end

  always_comb begin
    case (ctrl.uop.op)
      UOP_MUL: wdata = mul_res;
      UOP_DIV: wdata = div_res;
      default: wdata = add_res;
    endcase
  end

  assign tidx = TMP_IW'(ctrl.uop.dst - OP_DT2);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (ctrl.uop.dst >= OP_DT2)) begin
      tmp[tidx] <= wdata;
    end
  end

  // configuration writes, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= DT_RESET;
      meas_noise_x <= NOISE_RESET;
      meas_noise_y <= NOISE_RESET;
      meas_noise_z <= NOISE_RESET;
      accel_noise  <= NOISE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TIME_STEP:    time_step    <= cfg_data[DT_W-1:0];
        REG_MEAS_NOISE_X: meas_noise_x <= cfg_data;
        REG_MEAS_NOISE_Y: meas_noise_y <= cfg_data;
        REG_MEAS_NOISE_Z: meas_noise_z <= cfg_data;
        REG_ACCEL_NOISE:  accel_noise  <= cfg_data;
        default:          time_step    <= time_step;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mx    <= meas_x;  my    <= meas_y;  mz    <= meas_z;
      ax_in <= accel_x; ay_in <= accel_y; az_in <= accel_z;
    end
  end

  // filter state: writes into slot 0, rotation after each axis
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        est_p[i] <= '0;
        est_v[i] <= '0;
        cov0[i]  <= TEN_FX;
        cov1[i]  <= '0;
        cov2[i]  <= TEN_FX;
      end
      pacc_x <= '0;
      pacc_y <= '0;
      pacc_z <= '0;
    end else begin
      if (ctrl.rotate) begin
        for (int i = 0; i < 3; i++) begin
          est_p[i] <= est_p[(i+1)%3];
          est_v[i] <= est_v[(i+1)%3];
          cov0[i]  <= cov0[(i+1)%3];
          cov1[i]  <= cov1[(i+1)%3];
          cov2[i]  <= cov2[(i+1)%3];
        end
      end else if (ctrl.wr_en) begin
        case (ctrl.uop.dst)
          OP_EP:   est_p[0] <= wdata;
          OP_EV:   est_v[0] <= wdata;
          OP_C0:   cov0[0]  <= wdata;
          OP_C1:   cov1[0]  <= wdata;
          OP_C2:   cov2[0]  <= wdata;
          default: est_p[0] <= est_p[0];
        endcase
      end
      // accelerations of this item drive the next prediction
      if (ctrl.finish) begin
        pacc_x <= ax_in;
        pacc_y <= ay_in;
        pacc_z <= az_in;
      end
    end
  end

  // output register, filled when the last axis is finished
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      pos_x <= est_p[0]; vel_x <= est_v[0];
      pos_y <= est_p[1]; vel_y <= est_v[1];
      pos_z <= est_p[2]; vel_z <= est_v[2];
    end
  end

  // one item in work at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("input taken while an item is in work");

  // divide results are written only on divider completion
  a_div_wb: assert property (@(posedge clk) disable iff (rst)
    (ctrl.wr_en && ctrl.wait_div) |-> div_done)
    else $error("gain written before divider finished");

  // a finished item always lands in the output register
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |=> out_valid)
    else $error("finished item not presented");

endmodule

`default_nettype wire

// File: hw/rtl/kt_mul.sv
// ----------------------------------------------------------------------------
// kt_mul: shared fixed-point multiplier
// registered 32x32 product, then round to nearest and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module kt_mul
  import kt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0]      res
);

  localparam logic signed [2*DATA_W-1:0] RND = (2*DATA_W)'(64'sd1 <<< (FRAC_BITS - 1));

  logic signed [2*DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] rnd;
  logic signed [2*DATA_W-1:0] sh;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_comb begin
    rnd = prod + RND;
    sh  = rnd >>> FRAC_BITS;
    if (sh > (2*DATA_W)'(MAX_FX)) begin
      res = MAX_FX;
    end else if (sh < (2*DATA_W)'(MIN_FX)) begin
      res = MIN_FX;
    end else begin
      res = sh[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/kt_div.sv
// ----------------------------------------------------------------------------
// kt_div: iterative gain divider
// radix-2 restoring division of num * 2^frac by (p00 + r), toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module kt_div
  import kt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     go,
  input  wire logic signed [DATA_W-1:0] num,
  input  wire logic signed [DATA_W-1:0] p00,
  input  wire logic signed [DATA_W-1:0] r,
  output logic                          done,
  output logic signed [DATA_W-1:0]      res
);

  logic                   busy;
  logic [DIV_CNT_W-1:0]   cnt;
  logic                   neg;
  logic                   zero;
  logic [DATA_W:0]        dvs;
  logic [DATA_W:0]        rem;
  logic [NUM_W-1:0]       quo;

  logic signed [DATA_W+1:0] ssum;
  logic [DATA_W-1:0]        nmag;
  logic [DATA_W+1:0]        shifted;
  logic [DATA_W+2:0]        diff;

  assign ssum    = {{2{p00[DATA_W-1]}}, p00} + {{2{r[DATA_W-1]}}, r};
  assign nmag    = num[DATA_W-1] ? DATA_W'(-{num[DATA_W-1], num}) : num;
  assign shifted = {rem, quo[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (go) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg  <= num[DATA_W-1];
      zero <= ssum[DATA_W+1] || (ssum == '0);
      dvs  <= ssum[DATA_W:0];
      rem  <= '0;
      quo  <= {nmag, {FRAC_BITS{1'b0}}};
    end else if (busy) begin
      if (!diff[DATA_W+2]) begin
        rem <= diff[DATA_W:0];
      end else begin
        rem <= shifted[DATA_W:0];
      end
      quo <= {quo[NUM_W-2:0], !diff[DATA_W+2]};
    end
  end

  // sign and saturation of the magnitude quotient, zero for a non-positive divisor
  always_comb begin
    if (zero) begin
      res = '0;
    end else if (neg) begin
      if (quo > NUM_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
        res = MIN_FX;
      end else begin
        res = -DATA_W'(quo[DATA_W-1:0]);
      end
    end else if (quo > NUM_W'(MAX_FX)) begin
      res = MAX_FX;
    end else begin
      res = quo[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/kt_seq.sv
// ----------------------------------------------------------------------------
// kt_seq: microcode sequencer
// walks the common program once and the axis program three times
// ----------------------------------------------------------------------------
`default_nettype none

module kt_seq
  import kt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic div_done,
  input  wire logic out_busy,
  output logic      idle,
  output ctrl_t     ctrl
);

  seq_state_t      state, state_next;
  logic [PC_W-1:0] pc;
  logic [1:0]      axis;
  uop_t            uop;

  assign uop = prog(pc);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (start) state_next = ST_EXEC;
      ST_EXEC: begin
        unique case (uop.op)
          UOP_MUL: state_next = ST_MULWB;
          UOP_DIV: state_next = ST_DIVWAIT;
          default: state_next = (pc == PROG_LAST) ? ST_ROTATE : ST_EXEC;
        endcase
      end
      ST_MULWB:   state_next = (pc == PROG_LAST) ? ST_ROTATE : ST_EXEC;
      ST_DIVWAIT: if (div_done) state_next = (pc == PROG_LAST) ? ST_ROTATE : ST_EXEC;
      ST_ROTATE:  state_next = (axis == 2'd2) ? ST_DONE : ST_EXEC;
      ST_DONE:    if (!out_busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.uop      = uop;
    ctrl.axis     = axis;
    ctrl.wait_div = (state == ST_DIVWAIT);
    unique case (state)
      ST_EXEC: begin
        ctrl.wr_en  = (uop.op == UOP_ADD) || (uop.op == UOP_SUB);
        ctrl.div_go = (uop.op == UOP_DIV);
      end
      ST_MULWB:   ctrl.wr_en  = 1'b1;
      ST_DIVWAIT: ctrl.wr_en  = div_done;
      ST_ROTATE:  ctrl.rotate = 1'b1;
      ST_DONE:    ctrl.finish = !out_busy;
      default:    ctrl.wr_en  = 1'b0;
    endcase
  end

  assign idle = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        pc   <= '0;
        axis <= '0;
      end else if (state == ST_ROTATE) begin
        pc   <= AXIS_START;
        axis <= axis + 2'd1;
      end else if (ctrl.wr_en) begin
        pc <= pc + PC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the three-axis constant-velocity tracker
// drives measurement and acceleration items through a directed table and a
// random run under several register settings, and compares every estimate
// with a typed-in set or an in-bench fixed-point predictor of the filter
// ----------------------------------------------------------------------------

module tb
  import kt_pkg::*;
;

  typedef logic signed [DATA_W-1:0] fx_t;

  typedef struct {
    fx_t meas [3];
    fx_t accel [3];
  } track_in_t;

  typedef struct {
    fx_t est [6];
  } track_out_t;

  // directed row: the item, and an optional typed-in estimate set
  typedef struct {
    track_in_t  item;
    bit         fixed;
    track_out_t known;
  } drow_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  fx_t meas_x = '0, meas_y = '0, meas_z = '0;
  fx_t accel_x = '0, accel_y = '0, accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fx_t pos_x, vel_x, pos_y, vel_y, pos_z, vel_z;

  kalman_tracker_3axis dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .meas_x(meas_x), .meas_y(meas_y), .meas_z(meas_z),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .vel_x(vel_x), .pos_y(pos_y), .vel_y(vel_y),
    .pos_z(pos_z), .vel_z(vel_z)
  );

  always #10 clk = ~clk;

  // predictor copy of the filter state and registers
  longint trk_dt, trk_sig [3], trk_sa;
  longint trk_est [6], trk_cov [9], trk_acc [3];

  track_out_t estimate_q [$];
  int  n_fail = 0;
  int  stall_mode = 0;

  function automatic longint sat_fx(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // rounded product, floor of the shifted value
  function automatic longint mul_fx(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
    return sat_fx(p >>> FRAC_BITS);
  endfunction

  function automatic longint gain_fx(longint num, longint s);
    if (s <= 0) return 0;
    return sat_fx((num * (64'sd1 <<< FRAC_BITS)) / s);
  endfunction

  task automatic tracker_reset_state();
    trk_dt = 6554;
    trk_sa = 65536;
    for (int i = 0; i < 3; i++) begin
      trk_sig[i] = 65536;
      trk_est[2*i] = 0;
      trk_est[2*i+1] = 0;
      trk_cov[3*i] = longint'(TEN_FX);
      trk_cov[3*i+1] = 0;
      trk_cov[3*i+2] = longint'(TEN_FX);
      trk_acc[i] = 0;
    end
  endtask

  task automatic tracker_update(input track_in_t it, output track_out_t res);
    longint one, dt2, dt3, dt4, s2, qpp, qpv, qvv, gp, r;
    longint p, v, t, p00, p01, p11, s, k0, k1, y, ga, gb;
    longint m00, m01, m10, m11, kr0, kr1, acc;
    one = 64'sd1 <<< FRAC_BITS;
    dt2 = mul_fx(trk_dt, trk_dt);
    dt3 = mul_fx(dt2, trk_dt);
    dt4 = mul_fx(dt3, trk_dt);
    s2  = mul_fx(trk_sa, trk_sa);
    qpp = mul_fx(mul_fx(dt4, longint'(QUARTER_FX)), s2);
    qpv = mul_fx(mul_fx(dt3, longint'(HALF_FX)), s2);
    qvv = mul_fx(dt2, s2);
    gp  = mul_fx(dt2, longint'(HALF_FX));
    for (int ax = 0; ax < 3; ax++) begin
      r = mul_fx(trk_sig[ax], trk_sig[ax]);
      acc = trk_acc[ax];
      // predict
      p = sat_fx(trk_est[2*ax] + mul_fx(trk_dt, trk_est[2*ax+1]) + mul_fx(gp, acc));
      v = sat_fx(trk_est[2*ax+1] + mul_fx(trk_dt, acc));
      t = sat_fx(trk_cov[3*ax+1] + mul_fx(trk_dt, trk_cov[3*ax+2]));
      p00 = sat_fx(trk_cov[3*ax] + mul_fx(trk_dt, trk_cov[3*ax+1])
                   + mul_fx(trk_dt, t) + qpp);
      p01 = sat_fx(t + qpv);
      p11 = sat_fx(trk_cov[3*ax+2] + qvv);
      // gain and correction
      s = p00 + r;
      k0 = gain_fx(p00, s);
      k1 = gain_fx(p01, s);
      y = sat_fx(longint'(it.meas[ax]) - p);
      trk_est[2*ax]   = sat_fx(p + mul_fx(k0, y));
      trk_est[2*ax+1] = sat_fx(v + mul_fx(k1, y));
      // joseph-form covariance
      ga = sat_fx(one - k0);
      gb = sat_fx(-k1);
      m00 = mul_fx(ga, p00);
      m01 = mul_fx(ga, p01);
      m10 = sat_fx(mul_fx(gb, p00) + p01);
      m11 = sat_fx(mul_fx(gb, p01) + p11);
      kr0 = mul_fx(k0, r);
      kr1 = mul_fx(k1, r);
      trk_cov[3*ax]   = sat_fx(mul_fx(m00, ga) + mul_fx(kr0, k0));
      trk_cov[3*ax+1] = sat_fx(mul_fx(m00, gb) + m01 + mul_fx(kr0, k1));
      trk_cov[3*ax+2] = sat_fx(mul_fx(m10, gb) + m11 + mul_fx(kr1, k1));
    end
    for (int i = 0; i < 3; i++) trk_acc[i] = longint'(it.accel[i]);
    for (int i = 0; i < 6; i++) res.est[i] = fx_t'(trk_est[i]);
  endtask

  // register write, mirrored into the predictor with masking
  task automatic write_reg(input int idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_TIME_STEP:    trk_dt = longint'(val[DT_W-1:0]);
      REG_MEAS_NOISE_X: trk_sig[0] = longint'(val);
      REG_MEAS_NOISE_Y: trk_sig[1] = longint'(val);
      REG_MEAS_NOISE_Z: trk_sig[2] = longint'(val);
      REG_ACCEL_NOISE:  trk_sa = longint'(val);
      default: ;
    endcase
  endtask

  // hold valid until the transfer happens, then queue the expected estimates
  task automatic send_item(input track_in_t it, input bit fixed, input track_out_t known);
    track_out_t pred;
    in_valid <= 1'b1;
    meas_x <= it.meas[0]; meas_y <= it.meas[1]; meas_z <= it.meas[2];
    accel_x <= it.accel[0]; accel_y <= it.accel[1]; accel_z <= it.accel[2];
    do @(posedge clk); while (!in_ready);
    tracker_update(it, pred);
    estimate_q.push_back(fixed ? known : pred);
    @(negedge clk);
  endtask

  // let the block settle once every estimate is back
  task automatic wait_idle();
    while (estimate_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  function automatic fx_t rnd_fx(int mode);
    case (mode)
      0: return fx_t'($urandom);
      1: return fx_t'($urandom_range(0, 32'h00200000)) - fx_t'(32'h00100000);
      default: return $urandom_range(0, 1) ? MAX_FX : MIN_FX;
    endcase
  endfunction

  function automatic track_in_t rnd_item();
    track_in_t it;
    int mode;
    mode = ($urandom_range(0, 9) < 7) ? 1 : (($urandom_range(0, 3) == 0) ? 2 : 0);
    for (int i = 0; i < 3; i++) begin
      it.meas[i] = rnd_fx(mode);
      it.accel[i] = rnd_fx($urandom_range(0, 9) < 8 ? 1 : 0);
    end
    return it;
  endfunction

  // receiver: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    track_out_t exp_r;
    fx_t got [6];
    if (!rst && out_valid && out_ready) begin
      got = '{pos_x, vel_x, pos_y, vel_y, pos_z, vel_z};
      if (estimate_q.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        n_fail++;
      end else begin
        exp_r = estimate_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[i] !== exp_r.est[i]) begin
            $display("%0t: estimate %0d expected %0d actual %0d", $time, i,
                     exp_r.est[i], got[i]);
            n_fail++;
          end
      end
    end
  end

  // receiver stall pattern, switching between steady, random and bursty
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      default: out_ready <= ($urandom_range(0, 15) < 3);
    endcase
  end

  // watchdog: ~450 items plus gaps, stalls and settling
  initial begin
    #(20ns * 2000000);
    $display("kalman_tracker_3axis: mismatch");
    $finish;
  end

  initial begin
    drow_t dir [$];
    drow_t row;
    track_out_t none;
    int n_rand;
    int burst;
    for (int i = 0; i < 6; i++) none.est[i] = '0;
    tracker_reset_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first item after reset with zero measurement: estimate stays zero
    row.item.meas = '{0, 0, 0};
    row.item.accel = '{0, 0, 0};
    row.fixed = 1'b1;
    row.known = none;
    dir.push_back(row);
    row.fixed = 1'b0;
    row.item.meas = '{MAX_FX, MIN_FX, ONE_FX};
    row.item.accel = '{MAX_FX, MIN_FX, -ONE_FX};
    dir.push_back(row);
    row.item.meas = '{MIN_FX, MAX_FX, -ONE_FX};
    row.item.accel = '{MIN_FX, MAX_FX, 0};
    dir.push_back(row);
    row.item.meas = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_FFFF};
    row.item.accel = '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shFFFF_0000};
    dir.push_back(row);
    for (int i = 0; i < 4; i++) begin
      row.item.meas = '{TEN_FX, -TEN_FX, HALF_FX};
      row.item.accel = '{ONE_FX, -ONE_FX, QUARTER_FX};
      dir.push_back(row);
    end
    foreach (dir[k]) send_item(dir[k].item, dir[k].fixed, dir[k].known);
    in_valid <= 1'b0;
    wait_idle();

    // zero time step, zero x and acceleration noise: non-positive innovation variance possible
    write_reg(REG_TIME_STEP, 0);
    write_reg(REG_MEAS_NOISE_X, 0);
    write_reg(REG_MEAS_NOISE_Y, 24'hFFFFFF);
    write_reg(REG_MEAS_NOISE_Z, 24'h000001);
    write_reg(REG_ACCEL_NOISE, 0);
    write_reg(7, 24'h123456);
    foreach (dir[k]) if (k > 0) send_item(dir[k].item, 1'b0, none);
    in_valid <= 1'b0;
    wait_idle();

    // largest time step and noise: saturation everywhere
    write_reg(REG_TIME_STEP, 24'hFFFFFF);
    write_reg(REG_MEAS_NOISE_X, 24'hFFFFFF);
    write_reg(REG_ACCEL_NOISE, 24'hFFFFFF);
    write_reg(5, 0);
    for (int k = 1; k < 6; k++) send_item(dir[k].item, 1'b0, none);
    in_valid <= 1'b0;
    wait_idle();

    // random phases with random registers, one phase with time step and x noise at reset values
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_TIME_STEP, (ph == 0) ? 24'd6554 : $urandom_range(0, 24'h1FFFF));
      write_reg(REG_MEAS_NOISE_X, (ph == 0) ? 24'd65536 : $urandom_range(0, 24'h3FFFF));
      write_reg(REG_MEAS_NOISE_Y, $urandom_range(0, 24'hFFFFFF));
      write_reg(REG_MEAS_NOISE_Z, $urandom_range(0, 24'h3FFFF));
      write_reg(REG_ACCEL_NOISE, $urandom_range(0, 24'h3FFFF));
      n_rand = 0;
      while (n_rand < 72) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && n_rand < 72; b++) begin
          send_item(rnd_item(), 1'b0, none);
          n_rand++;
        end
        in_valid <= 1'b0;
        @(negedge clk);
        // occasionally hold off until every estimate is back
        if ($urandom_range(0, 5) == 0) begin
          while (estimate_q.size() != 0) @(negedge clk);
        end else begin
          repeat ($urandom_range(0, 40)) @(negedge clk);
        end
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    if (n_fail == 0) begin
      $display("kalman_tracker_3axis: match");
    end else begin
      $display("kalman_tracker_3axis: mismatch");
    end
    $finish;
  end

endmodule
